FILE: rtl/core/csc_pkg.sv
// Shared types, constants and arithmetic helpers for the climate compensation core.
`timescale 1ns / 1ps

package csc_pkg;

   localparam int DivStages = 32;

   localparam logic [31:0] PressOffset   = 32'd64000;
   localparam logic [31:0] PressBase     = 32'd1048576;
   localparam logic [31:0] PressScale    = 32'd3125;
   localparam logic [31:0] SignBit       = 32'h8000_0000;
   localparam logic [31:0] HumOffset     = 32'd76800;
   localparam logic [31:0] HumLimit      = 32'd419430400;
   localparam logic [31:0] HumBias       = 32'd2097152;
   localparam logic [31:0] HumRound      = 32'd16384;
   localparam logic [31:0] HalfScale     = 32'd32768;
   localparam logic [31:0] HumRoundSmall = 32'd8192;
   localparam logic [31:0] TempRound     = 32'd128;
   localparam logic [31:0] TempScale     = 32'd5;
   localparam logic [31:0] HumPercent    = 32'd25;

   localparam logic [2:0] RegTemp   = 3'd0;
   localparam logic [2:0] RegPressA = 3'd1;
   localparam logic [2:0] RegPressB = 3'd2;
   localparam logic [2:0] RegPress9 = 3'd3;
   localparam logic [2:0] RegHum    = 3'd4;

   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } coef_type;

   typedef struct packed {
      logic [18:0] temp;
      logic [31:0] hd;
      logic        bad;
      logic        mode2;
   } side_type;

   typedef struct packed {
      logic [18:0] temp;
      logic [31:0] pressure;
      logic        invalid;
      logic [13:0] humidity;
   } result_type;

   function automatic logic [31:0] asr(input logic [31:0] a, input int unsigned n);
      return 32'($signed(a) >>> n);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      return 32'(a * b);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

FILE: rtl/core/csc_front.sv
// Eight-stage front pipeline: temperature, pressure operands and humidity product.
`timescale 1ns / 1ps

module csc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  csc_pkg::coef_type coef,
   input  logic              in_valid,
   input  logic [19:0]       raw_temperature,
   input  logic [19:0]       raw_pressure,
   input  logic [15:0]       raw_humidity,
   output logic              out_valid,
   output logic [31:0]       dvd,
   output logic [31:0]       den,
   output csc_pkg::side_type side
);
   import csc_pkg::*;

   logic [7:0] v_ff, v_in;

   logic [31:0] m1_ff, m1_in, dd_ff, dd_in, adp1_ff, adp1_in, adh1_ff, adh1_in;
   logic [31:0] ta2_ff, ta2_in, m2_ff, m2_in, adp2_ff, adp2_in, adh2_ff, adh2_in;
   logic [31:0] temp3_ff, temp3_in, pa3_ff, pa3_in, hd3_ff, hd3_in;
   logic [31:0] adp3_ff, adp3_in, adh3_ff, adh3_in;
   logic [31:0] q4_ff, q4_in, mp5_ff, mp5_in, mp2_4_ff, mp2_4_in;
   logic [31:0] mh5_ff, mh5_in, mh6_ff, mh6_in, mh3_ff, mh3_in;
   logic [31:0] temp4_ff, temp4_in, adp4_ff, adp4_in, adh4_ff, adh4_in;
   logic [31:0] pb5_ff, pb5_in, a35_ff, a35_in, mp2_5_ff, mp2_5_in;
   logic [31:0] ha5_ff, ha5_in, hb1_ff, hb1_in, hb2_ff, hb2_in;
   logic [31:0] temp5_ff, temp5_in, adp5_ff, adp5_in;
   logic [31:0] pb6_ff, pb6_in, pa6_ff, pa6_in, hbm6_ff, hbm6_in;
   logic [31:0] ha6_ff, ha6_in, temp6_ff, temp6_in, adp6_ff, adp6_in;
   logic [31:0] den7_ff, den7_in, num7_ff, num7_in, hb7_ff, hb7_in;
   logic [31:0] ha7_ff, ha7_in, temp7_ff, temp7_in;
   logic [31:0] dvd8_ff, dvd8_in, den8_ff, den8_in;
   side_type    side8_ff, side8_in;

   logic [31:0] adt, x1, dt, fine, t5, pscale;

   always_comb begin
      v_in = {v_ff[6:0], in_valid};

      // Stage 1: first temperature products.
      adt     = {12'd0, raw_temperature};
      x1      = (adt >> 3) - (coef.t1 << 1);
      dt      = (adt >> 4) - coef.t1;
      m1_in   = mul32(x1, coef.t2);
      dd_in   = mul32(dt, dt);
      adp1_in = {12'd0, raw_pressure};
      adh1_in = {16'd0, raw_humidity};

      // Stage 2.
      ta2_in  = asr(m1_ff, 11);
      m2_in   = mul32(asr(dd_ff, 12), coef.t3);
      adp2_in = adp1_ff;
      adh2_in = adh1_ff;

      // Stage 3: fine value and the offsets derived from it.
      fine     = ta2_ff + asr(m2_ff, 14);
      t5       = mul32(fine, TempScale);
      temp3_in = asr(t5 + TempRound, 8);
      pa3_in   = asr(fine, 1) - PressOffset;
      hd3_in   = fine - HumOffset;
      adp3_in  = adp2_ff;
      adh3_in  = adh2_ff;

      // Stage 4: products of the offsets with coefficients.
      q4_in    = mul32(asr(pa3_ff, 2), asr(pa3_ff, 2));
      mp5_in   = mul32(pa3_ff, coef.p5);
      mp2_4_in = mul32(coef.p2, pa3_ff);
      mh5_in   = mul32(coef.h5, hd3_ff);
      mh6_in   = mul32(hd3_ff, coef.h6);
      mh3_in   = mul32(hd3_ff, coef.h3);
      temp4_in = temp3_ff;
      adp4_in  = adp3_ff;
      adh4_in  = adh3_ff;

      // Stage 5.
      pb5_in   = mul32(asr(q4_ff, 11), coef.p6) + (mp5_ff << 1);
      a35_in   = mul32(coef.p3, asr(q4_ff, 13));
      mp2_5_in = mp2_4_ff;
      ha5_in   = asr((adh4_ff << 14) - (coef.h4 << 20) - mh5_ff + HumRound, 15);
      hb1_in   = asr(mh6_ff, 10);
      hb2_in   = asr(mh3_ff, 11) + HalfScale;
      temp5_in = temp4_ff;
      adp5_in  = adp4_ff;

      // Stage 6.
      pb6_in   = asr(pb5_ff, 2) + (coef.p4 << 16);
      pa6_in   = asr(asr(a35_ff, 3) + asr(mp2_5_ff, 1), 18);
      hbm6_in  = mul32(hb1_ff, hb2_ff);
      ha6_in   = ha5_ff;
      temp6_in = temp5_ff;
      adp6_in  = adp5_ff;

      // Stage 7: raw divisor and numerator.
      den7_in  = mul32(HalfScale + pa6_ff, coef.p1);
      pscale   = (PressBase - adp6_ff) - asr(pb6_ff, 12);
      num7_in  = mul32(pscale, PressScale);
      hb7_in   = asr(mul32(asr(hbm6_ff, 10) + HumBias, coef.h2) + HumRoundSmall, 14);
      ha7_in   = ha6_ff;
      temp7_in = temp6_ff;

      // Stage 8: the numerator is doubled before the divide unless that would overflow.
      den8_in        = asr(den7_ff, 15);
      side8_in.mode2 = (num7_ff >= SignBit);
      dvd8_in        = side8_in.mode2 ? num7_ff : (num7_ff << 1);
      side8_in.bad   = (den8_in == 32'd0);
      side8_in.hd    = mul32(ha7_ff, hb7_ff);
      side8_in.temp  = temp7_ff[18:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         m1_ff <= m1_in;  dd_ff <= dd_in;  adp1_ff <= adp1_in;  adh1_ff <= adh1_in;
         ta2_ff <= ta2_in;  m2_ff <= m2_in;  adp2_ff <= adp2_in;  adh2_ff <= adh2_in;
         temp3_ff <= temp3_in;  pa3_ff <= pa3_in;  hd3_ff <= hd3_in;
         adp3_ff <= adp3_in;  adh3_ff <= adh3_in;
         q4_ff <= q4_in;  mp5_ff <= mp5_in;  mp2_4_ff <= mp2_4_in;
         mh5_ff <= mh5_in;  mh6_ff <= mh6_in;  mh3_ff <= mh3_in;
         temp4_ff <= temp4_in;  adp4_ff <= adp4_in;  adh4_ff <= adh4_in;
         pb5_ff <= pb5_in;  a35_ff <= a35_in;  mp2_5_ff <= mp2_5_in;
         ha5_ff <= ha5_in;  hb1_ff <= hb1_in;  hb2_ff <= hb2_in;
         temp5_ff <= temp5_in;  adp5_ff <= adp5_in;
         pb6_ff <= pb6_in;  pa6_ff <= pa6_in;  hbm6_ff <= hbm6_in;
         ha6_ff <= ha6_in;  temp6_ff <= temp6_in;  adp6_ff <= adp6_in;
         den7_ff <= den7_in;  num7_ff <= num7_in;  hb7_ff <= hb7_in;
         ha7_ff <= ha7_in;  temp7_ff <= temp7_in;
         dvd8_ff <= dvd8_in;  den8_ff <= den8_in;  side8_ff <= side8_in;
      end
   end

   assign out_valid = v_ff[7];
   assign dvd       = dvd8_ff;
   assign den       = den8_ff;
   assign side      = side8_ff;

endmodule

FILE: rtl/core/csc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`timescale 1ns / 1ps

module csc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       dvd,
   input  logic [31:0]       den,
   input  csc_pkg::side_type side_in,
   output logic              out_valid,
   output logic [31:0]       quo,
   output csc_pkg::side_type side_out
);
   import csc_pkg::*;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dq;
      logic [31:0] den;
      side_type    side;
   } div_stage_type;

   div_stage_type stg_ff [DivStages];
   div_stage_type stg_in [DivStages];
   div_stage_type prev   [DivStages];
   logic [DivStages-1:0] vld_ff, vld_in;

   assign vld_in = {vld_ff[DivStages-2:0], in_valid};

   for (genvar i = 0; i < DivStages; i++) begin : g_stage
      logic [32:0] sh, diff;
      if (i == 0) begin : g_first
         assign prev[i] = '{rem: 32'd0, dq: dvd, den: den, side: side_in};
      end else begin : g_next
         assign prev[i] = stg_ff[i-1];
      end

      // The dividend shifts out at the top while quotient bits shift in at the bottom.
      always_comb begin
         sh = {prev[i].rem, prev[i].dq[31]};
         diff = sh - {1'b0, prev[i].den};
         stg_in[i] = prev[i];
         if (!diff[32]) begin
            stg_in[i].rem = diff[31:0];
            stg_in[i].dq  = {prev[i].dq[30:0], 1'b1};
         end else begin
            stg_in[i].rem = sh[31:0];
            stg_in[i].dq  = {prev[i].dq[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff[DivStages-1];
   assign quo       = stg_ff[DivStages-1].dq;
   assign side_out  = stg_ff[DivStages-1].side;

endmodule

FILE: rtl/core/csc_back.sv
// Three-stage back pipeline: pressure correction, humidity finish and output register.
`timescale 1ns / 1ps

module csc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  csc_pkg::coef_type   coef,
   input  logic                in_valid,
   input  logic [31:0]         quo,
   input  csc_pkg::side_type   side,
   output logic                out_valid,
   output csc_pkg::result_type res
);
   import csc_pkg::*;

   logic [2:0]  v_ff, v_in;
   logic [31:0] p1_ff, p1_in, sq1_ff, sq1_in, m8_1_ff, m8_1_in, hq1_ff, hq1_in;
   logic [31:0] p2_ff, p2_in, pa9_ff, pa9_in, m8_2_ff, m8_2_in, hm2_ff, hm2_in;
   side_type    side1_ff, side1_in, side2_ff, side2_in;
   result_type  res_ff, res_in;
   logic [31:0] pq, hs, hd, hclip, hmul;

   always_comb begin
      v_in = {v_ff[1:0], in_valid};

      p1_in    = side.mode2 ? (quo << 1) : quo;
      pq       = p1_in >> 3;
      sq1_in   = mul32(pq, pq);
      m8_1_in  = mul32(p1_in >> 2, coef.p8);
      hs       = asr(side.hd, 15);
      hq1_in   = mul32(hs, hs);
      side1_in = side;

      pa9_in   = asr(mul32(coef.p9, sq1_ff >> 13), 12);
      hm2_in   = mul32(asr(hq1_ff, 7), coef.h1);
      p2_in    = p1_ff;
      m8_2_in  = m8_1_ff;
      side2_in = side1_ff;

      // A zero divisor forces the pressure to zero.
      res_in.invalid  = side2_ff.bad;
      res_in.pressure = side2_ff.bad ? 32'd0 :
                        p2_ff + asr(pa9_ff + asr(m8_2_ff, 13) + coef.p7, 4);
      res_in.temp     = side2_ff.temp;
      hd = side2_ff.hd - asr(hm2_ff, 4);
      if (hd[31]) begin
         hclip = 32'd0;
      end else if (hd > HumLimit) begin
         hclip = HumLimit;
      end else begin
         hclip = hd;
      end
      hmul = mul32(hclip >> 12, HumPercent) >> 8;
      res_in.humidity = hmul[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         p1_ff <= p1_in;  sq1_ff <= sq1_in;  m8_1_ff <= m8_1_in;  hq1_ff <= hq1_in;
         side1_ff <= side1_in;
         p2_ff <= p2_in;  pa9_ff <= pa9_in;  m8_2_ff <= m8_2_in;  hm2_ff <= hm2_in;
         side2_ff <= side2_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = v_ff[2];
   assign res       = res_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && res.invalid |-> res.pressure == 32'd0)
      else $error("invalid pressure result is not zero");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> res.humidity <= 14'd10000)
      else $error("humidity result above full scale");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en && out_valid |=> out_valid && $stable(res))
      else $error("result changed while the pipeline was frozen");

endmodule

FILE: rtl/core/climate_sensor_compensation_core.sv
// Top level of the climate sensor compensation core.
//
// One raw triple (temperature, pressure, humidity) enters on the req_ channel and
// one compensated triple leaves on the rsp_ channel. A transfer happens on a rising
// clock edge where valid is high and stall is low.
// The datapath is a 43-stage pipeline: 8 front stages for temperature and the
// pressure and humidity operands, 32 stages of a restoring divider that yields one
// quotient bit per stage, and 3 back stages ending in the output register.
// rsp_valid rises when a triple reaches the output register, and one triple is
// taken every cycle while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline freezes and req_stall
// rises in the same cycle, so nothing is dropped or repeated.
// The user writes calibration words through csr_ only while the core is idle, which
// the block does not enforce. Reset clears them to zero and empties the pipeline.
`timescale 1ns / 1ps

module climate_sensor_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [18:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_pa,
   output logic        rsp_pressure_invalid,
   output logic [13:0] rsp_humidity_centi,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import csc_pkg::*;

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_a_ff, press_b_ff, hum_ff;
   logic [15:0] press_nine_ff;
   coef_type    coef;
   logic        en;
   logic        front_valid, div_valid;
   logic [31:0] dvd, den, quo;
   side_type    front_side, div_side;
   result_type  res;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_nine_ff  <= '0;
         hum_ff         <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            RegTemp:   temp_coeffs_ff <= csr_wdata[47:0];
            RegPressA: press_a_ff     <= csr_wdata;
            RegPressB: press_b_ff     <= csr_wdata;
            RegPress9: press_nine_ff  <= csr_wdata[15:0];
            RegHum:    hum_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.t1 = {16'd0, temp_coeffs_ff[15:0]};
      coef.t2 = sx16(temp_coeffs_ff[31:16]);
      coef.t3 = sx16(temp_coeffs_ff[47:32]);
      coef.p1 = {16'd0, press_a_ff[15:0]};
      coef.p2 = sx16(press_a_ff[31:16]);
      coef.p3 = sx16(press_a_ff[47:32]);
      coef.p4 = sx16(press_a_ff[63:48]);
      coef.p5 = sx16(press_b_ff[15:0]);
      coef.p6 = sx16(press_b_ff[31:16]);
      coef.p7 = sx16(press_b_ff[47:32]);
      coef.p8 = sx16(press_b_ff[63:48]);
      coef.p9 = sx16(press_nine_ff);
      coef.h1 = {24'd0, hum_ff[7:0]};
      coef.h2 = sx16(hum_ff[23:8]);
      coef.h3 = {24'd0, hum_ff[31:24]};
      coef.h4 = sx12(hum_ff[43:32]);
      coef.h5 = sx12(hum_ff[55:44]);
      coef.h6 = sx8(hum_ff[63:56]);
   end

   // The pipeline moves as one unless a finished result is held by the receiver.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   csc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .coef            (coef),
      .in_valid        (req_valid),
      .raw_temperature (req_raw_temperature),
      .raw_pressure    (req_raw_pressure),
      .raw_humidity    (req_raw_humidity),
      .out_valid       (front_valid),
      .dvd             (dvd),
      .den             (den),
      .side            (front_side)
   );

   csc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .dvd       (dvd),
      .den       (den),
      .side_in   (front_side),
      .out_valid (div_valid),
      .quo       (quo),
      .side_out  (div_side)
   );

   csc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .coef      (coef),
      .in_valid  (div_valid),
      .quo       (quo),
      .side      (div_side),
      .out_valid (rsp_valid),
      .res       (res)
   );

   assign rsp_temperature_centi = $signed(res.temp);
   assign rsp_pressure_pa       = res.pressure;
   assign rsp_pressure_invalid  = res.invalid;
   assign rsp_humidity_centi    = res.humidity;

endmodule
